### rtl/b64e_pkg.sv
// shared types, register indexes and the alphabet lookup for the base64 stream encoder
// no dependencies
package b64e_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_URL_ALPHABET = 2'd0;
    localparam logic [1:0] REG_PAD_OUTPUT   = 2'd1;

    localparam logic [6:0] PAD_CHAR = 7'h3d;

    // one input byte of the message
    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_in_item;

    // one encoded character
    typedef struct packed {
        logic [6:0] text_char;
        logic       last_char;
    } t_out_item;

    // group request from front to back
    typedef struct packed {
        logic [23:0] group;
        logic [1:0]  last_idx;   // index of the last data character (1..3)
        logic        fin;        // group closes the message
    } t_grp_req;

    // map a 6-bit index onto the chosen alphabet
    function automatic logic [6:0] map_index(input logic [5:0] idx, input logic url);
        logic [6:0] ch;
        if (idx < 6'd26) begin
            ch = 7'h41 + {1'b0, idx};
        end else if (idx < 6'd52) begin
            ch = 7'h61 + {1'b0, idx - 6'd26};
        end else if (idx < 6'd62) begin
            ch = 7'h30 + {1'b0, idx - 6'd52};
        end else if (idx == 6'd62) begin
            ch = url ? 7'h2d : 7'h2b;
        end else begin
            ch = url ? 7'h5f : 7'h2f;
        end
        return ch;
    endfunction

endpackage

### rtl/b64e_fifo.sv
// two-entry queue for any packed type
// no package dependencies
module b64e_fifo #(
    parameter type T = logic
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  T     i_wdata,
    output logic o_full,
    input  logic i_rd,
    output T     o_rdata,
    output logic o_empty
);
    T           r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       n_wr_ptr;
    logic       n_rd_ptr;
    logic [1:0] n_count;
    logic       do_wr;
    logic       do_rd;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;

    // pointer and fill update
    always_comb begin
        n_wr_ptr = do_wr ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = do_rd ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (do_wr && !do_rd) begin
            n_count = r_count + 2'd1;
        end else if (do_rd && !do_wr) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

### rtl/b64e_front.sv
// front end: gathers bytes into 24-bit groups and issues group requests
// depends on b64e_pkg
module b64e_front
    import b64e_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    output logic     o_req_valid,
    output t_grp_req o_req
);
    logic [15:0] r_pend;
    logic [1:0]  r_cnt;
    logic [15:0] n_pend;
    logic [1:0]  n_cnt;
    logic [1:0]  cnt_inc;

    // count including this byte, a stray three counts as empty
    assign cnt_inc = ((r_cnt == 2'd3) ? 2'd0 : r_cnt) + 2'd1;

    // classify the byte
    always_comb begin
        o_req_valid    = 1'b0;
        o_req.fin      = i_item.final_byte;
        o_req.group    = {r_pend, i_item.data_byte};
        o_req.last_idx = 2'd3;
        n_pend         = r_pend;
        n_cnt          = r_cnt;
        if (i_accept) begin
            if (cnt_inc == 2'd3) begin
                o_req_valid = 1'b1;
                n_pend      = 16'd0;
                n_cnt       = 2'd0;
            end else if (!i_item.final_byte) begin
                n_pend = (cnt_inc == 2'd1) ? {8'd0, i_item.data_byte}
                                           : {r_pend[7:0], i_item.data_byte};
                n_cnt  = cnt_inc;
            end else begin
                o_req_valid = 1'b1;
                n_pend      = 16'd0;
                n_cnt       = 2'd0;
                if (cnt_inc == 2'd2) begin
                    o_req.group    = {r_pend[7:0], i_item.data_byte, 8'd0};
                    o_req.last_idx = 2'd2;
                end else begin
                    o_req.group    = {i_item.data_byte, 16'd0};
                    o_req.last_idx = 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 16'd0;
            r_cnt  <= 2'd0;
        end else begin
            r_pend <= n_pend;
            r_cnt  <= n_cnt;
        end
    end

endmodule

### rtl/b64e_back.sv
// back end: turns one group request into characters, one per cycle while the result queue has room
// depends on b64e_pkg
module b64e_back
    import b64e_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_url,
    input  logic      i_pad,
    input  logic      i_req_valid,
    input  t_grp_req  i_req,
    output logic      o_req_pop,
    input  logic      i_out_full,
    output logic      o_out_wr,
    output t_out_item o_out
);
    logic [1:0] r_k;
    logic [1:0] n_k;
    logic [1:0] tot_last;
    logic [5:0] idx;
    logic       at_end;

    // index of the final character including padding
    assign tot_last = (i_req.fin && i_pad) ? 2'd3 : i_req.last_idx;
    assign at_end   = (r_k == tot_last);
    assign o_out_wr = i_req_valid && !i_out_full;
    assign o_req_pop = o_out_wr && at_end;

    // select the sextet for this character
    always_comb begin
        case (r_k)
            2'd0:    idx = i_req.group[23:18];
            2'd1:    idx = i_req.group[17:12];
            2'd2:    idx = i_req.group[11:6];
            default: idx = i_req.group[5:0];
        endcase
    end

    // character and end mark
    always_comb begin
        o_out.text_char = (r_k <= i_req.last_idx) ? map_index(idx, i_url) : PAD_CHAR;
        o_out.last_char = i_req.fin && at_end;
    end

    always_comb begin
        n_k = r_k;
        if (o_out_wr) begin
            n_k = at_end ? 2'd0 : r_k + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= 2'd0;
        end else begin
            r_k <= n_k;
        end
    end

endmodule

### rtl/base64_stream_encoder_top.sv
// top level of the base64 stream encoder: config registers, front, back and queues
// depends on b64e_pkg, b64e_fifo, b64e_front, b64e_back
// Streaming base64 encoder: bytes are pushed one per cycle while not full, with a
// final flag on the last byte of a message; characters come out through a
// queue-style port, one per cycle while not empty, the last marked by last_char.
// Every third byte (or a final byte) makes a group request that waits in a
// two-entry queue; the back end then writes one character per cycle into the
// result queue while it has room: four for a full group, two to four for a
// final partial group. Registers: index 0 selects the URL-safe
// alphabet, index 1 enables '=' padding (reset 1); write them only while idle.
module base64_stream_encoder_top
    import b64e_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  t_in_item   i_in_item,
    output logic       empty,
    input  logic       pop,
    output t_out_item  o_out_item,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic       i_cfg_data
);
    logic      r_url;
    logic      r_pad;
    logic      req_valid;
    t_grp_req  req;
    logic      req_full;
    t_grp_req  head_req;
    logic      head_empty;
    logic      head_pop;
    logic      out_full;
    logic      out_wr;
    t_out_item out_item;
    logic      accept;

    assign o_cfg_ready = 1'b1;
    assign full        = req_full;
    assign accept      = push && !req_full;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_url <= 1'b0;
            r_pad <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_URL_ALPHABET: r_url <= i_cfg_data;
                REG_PAD_OUTPUT:   r_pad <= i_cfg_data;
                default: ;
            endcase
        end
    end

    b64e_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_in_item),
        .o_req_valid (req_valid),
        .o_req       (req)
    );

    // group request queue
    b64e_fifo #(.T(t_grp_req)) u_req_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (req_valid),
        .i_wdata (req),
        .o_full  (req_full),
        .i_rd    (head_pop),
        .o_rdata (head_req),
        .o_empty (head_empty)
    );

    b64e_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_url       (r_url),
        .i_pad       (r_pad),
        .i_req_valid (!head_empty),
        .i_req       (head_req),
        .o_req_pop   (head_pop),
        .i_out_full  (out_full),
        .o_out_wr    (out_wr),
        .o_out       (out_item)
    );

    // result queue
    b64e_fifo #(.T(t_out_item)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (out_wr),
        .i_wdata (out_item),
        .o_full  (out_full),
        .i_rd    (pop),
        .o_rdata (o_out_item),
        .o_empty (empty)
    );

endmodule

### verif/tb_base64_stream_encoder_top.sv
`timescale 1ns / 100ps
// testbench for base64_stream_encoder_top: a directed table, then random messages
// under every register setting, each character checked against typed text or a local encoder model
// depends on b64e_pkg and the encoder rtl
module tb_base64_stream_encoder_top;
    import b64e_pkg::*;

    localparam logic [511:0] STD_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    localparam logic [511:0] URL_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";
    localparam int SETTLE_CYCLES   = 16;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int N_ROWS          = 25;

    // one directed request, with the characters typed in where they are obvious
    typedef struct packed {
        logic        url_sel;
        logic        pad_on;
        logic [7:0]  data_byte;
        logic        final_byte;
        logic        typed;
        logic [31:0] text;
    } t_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       push;
    logic       full;
    t_in_item   i_in_item;
    logic       empty;
    logic       pop;
    t_out_item  o_out_item;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index;
    logic       i_cfg_data;

    // encoder model state and settings
    logic [15:0] held_bytes = '0;
    int          held_count = 0;
    logic        url_sel    = 1'b0;
    logic        pad_on     = 1'b1;

    t_out_item   expected_chars [$];
    t_out_item   fresh_chars [$];
    t_row        stim_rows [N_ROWS];
    int          error_count  = 0;
    logic        steady       = 1'b0;
    logic        hold_off_req = 1'b0;

    base64_stream_encoder_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_item   (i_in_item),
        .empty       (empty),
        .pop         (pop),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        else if (r < 85) return $urandom_range(1, 3);
        else if (r < 97) return $urandom_range(4, 12);
        else return $urandom_range(20, 60);
    endfunction

    function automatic t_row make_row(input logic url, input logic pad, input logic [7:0] data,
                                      input logic fin, input logic typed,
                                      input logic [31:0] text);
        t_row row;
        row.url_sel    = url;
        row.pad_on     = pad;
        row.data_byte  = data;
        row.final_byte = fin;
        row.typed      = typed;
        row.text       = text;
        return row;
    endfunction

    function automatic logic [6:0] alphabet_char(input logic [5:0] idx);
        int pos;
        pos = 8 * (63 - int'(idx));
        return url_sel ? URL_ALPHABET[pos +: 7] : STD_ALPHABET[pos +: 7];
    endfunction

    // characters caused by one accepted byte, left in fresh_chars
    task automatic encode_byte(input logic [7:0] data, input logic fin);
        int          cnt;
        int          ndata;
        int          total;
        logic [23:0] grp;
        t_out_item   c;
        fresh_chars.delete();
        cnt = held_count + 1;
        if (cnt == 3) begin
            grp   = {held_bytes, data};
            ndata = 4;
        end else if (!fin) begin
            held_bytes = {held_bytes[7:0], data};
            held_count = cnt;
            return;
        end else if (cnt == 2) begin
            grp   = {held_bytes[7:0], data, 8'h00};
            ndata = 3;
        end else begin
            grp   = {data, 16'h0000};
            ndata = 2;
        end
        total = (fin && ndata < 4 && pad_on) ? 4 : ndata;
        for (int k = 0; k < total; k++) begin
            c.text_char = (k < ndata) ? alphabet_char(grp[23 - 6 * k -: 6]) : PAD_CHAR;
            c.last_char = fin && (k == total - 1);
            fresh_chars = {fresh_chars, c};
        end
        held_bytes = '0;
        held_count = 0;
    endtask

    // offer one byte, then queue what it should produce
    task automatic send_byte(input logic [7:0] data, input logic fin, input logic typed,
                             input logic [31:0] text);
        int        gap;
        int        n;
        int        j;
        t_out_item c;
        gap = steady ? 0 : rand_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push      <= 1'b1;
        i_in_item <= {data, fin};
        do @(posedge i_clk); while (full);
        encode_byte(data, fin);
        if (typed) begin
            n = 0;
            for (int k = 0; k < 4; k++) begin
                if (text[8 * k +: 8] != 8'h00) n++;
            end
            j = 0;
            for (int k = 3; k >= 0; k--) begin
                if (text[8 * k +: 8] != 8'h00) begin
                    j++;
                    c.text_char = text[8 * k +: 7];
                    c.last_char = fin && (j == n);
                    expected_chars = {expected_chars, c};
                end
            end
        end else begin
            expected_chars = {expected_chars, fresh_chars};
        end
    endtask

    // sender pauses until every character is out and the encoder has gone quiet
    task automatic drain_encoder();
        push <= 1'b0;
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write both registers back to back, valid held across the two requests
    task automatic apply_settings(input logic url, input logic pad);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_URL_ALPHABET;
        i_cfg_data  <= url;
        do @(posedge i_clk); while (!o_cfg_ready);
        url_sel = url;
        i_cfg_index <= REG_PAD_OUTPUT;
        i_cfg_data  <= pad;
        do @(posedge i_clk); while (!o_cfg_ready);
        pad_on = pad;
        i_cfg_valid <= 1'b0;
    endtask

    // main stimulus
    initial begin : stimulus
        int         sent;
        int         msg_len;
        int         r;
        logic [1:0] combo;
        push        <= 1'b0;
        i_in_item   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= REG_URL_ALPHABET;
        i_cfg_data  <= 1'b0;
        i_rst_n     <= 1'b0;

        // reset settings: standard alphabet, padding on
        stim_rows[0]  = make_row(1'b0, 1'b1, "M",   1'b0, 1'b1, "");
        stim_rows[1]  = make_row(1'b0, 1'b1, "a",   1'b0, 1'b1, "");
        stim_rows[2]  = make_row(1'b0, 1'b1, "n",   1'b1, 1'b1, "TWFu");
        stim_rows[3]  = make_row(1'b0, 1'b1, "M",   1'b1, 1'b1, "TQ==");
        stim_rows[4]  = make_row(1'b0, 1'b1, "M",   1'b0, 1'b1, "");
        stim_rows[5]  = make_row(1'b0, 1'b1, "a",   1'b1, 1'b1, "TWE=");
        stim_rows[6]  = make_row(1'b0, 1'b1, 8'h00, 1'b0, 1'b1, "");
        stim_rows[7]  = make_row(1'b0, 1'b1, 8'h00, 1'b0, 1'b1, "");
        stim_rows[8]  = make_row(1'b0, 1'b1, 8'h00, 1'b1, 1'b1, "AAAA");
        stim_rows[9]  = make_row(1'b0, 1'b1, 8'hff, 1'b0, 1'b1, "");
        stim_rows[10] = make_row(1'b0, 1'b1, 8'hff, 1'b0, 1'b1, "");
        stim_rows[11] = make_row(1'b0, 1'b1, 8'hff, 1'b1, 1'b1, "////");
        // full group mid-message, then a lone final byte
        stim_rows[12] = make_row(1'b0, 1'b1, 8'hfb, 1'b0, 1'b1, "");
        stim_rows[13] = make_row(1'b0, 1'b1, 8'hef, 1'b0, 1'b1, "");
        stim_rows[14] = make_row(1'b0, 1'b1, 8'hbe, 1'b0, 1'b1, "++++");
        stim_rows[15] = make_row(1'b0, 1'b1, 8'hff, 1'b1, 1'b1, "/w==");
        // url alphabet, no padding
        stim_rows[16] = make_row(1'b1, 1'b0, 8'hfb, 1'b0, 1'b1, "");
        stim_rows[17] = make_row(1'b1, 1'b0, 8'hef, 1'b0, 1'b1, "");
        stim_rows[18] = make_row(1'b1, 1'b0, 8'hbe, 1'b1, 1'b1, "----");
        stim_rows[19] = make_row(1'b1, 1'b0, 8'hff, 1'b1, 1'b1, "_w");
        stim_rows[20] = make_row(1'b1, 1'b0, 8'hff, 1'b0, 1'b1, "");
        stim_rows[21] = make_row(1'b1, 1'b0, 8'hff, 1'b1, 1'b1, "__8");
        // url alphabet with padding, then standard without, model only
        stim_rows[22] = make_row(1'b1, 1'b1, "f",   1'b0, 1'b0, "");
        stim_rows[23] = make_row(1'b1, 1'b1, "o",   1'b1, 1'b0, "");
        stim_rows[24] = make_row(1'b0, 1'b0, 8'ha5, 1'b1, 1'b0, "");

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (stim_rows[i]) begin
            if (stim_rows[i].url_sel != url_sel || stim_rows[i].pad_on != pad_on) begin
                drain_encoder();
                apply_settings(stim_rows[i].url_sel, stim_rows[i].pad_on);
            end
            send_byte(stim_rows[i].data_byte, stim_rows[i].final_byte,
                      stim_rows[i].typed, stim_rows[i].text);
        end

        // random messages, one setting per phase
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: combo = 2'b00;
                1: combo = 2'b11;
                2: combo = 2'b10;
                3: combo = 2'b01;
                default: combo = 2'($urandom_range(0, 3));
            endcase
            drain_encoder();
            apply_settings(combo[1], combo[0]);
            // back to back on both sides; in phase 3 the receiver also holds off
            steady = (phase == 1) || (phase == 3);
            if (phase == 3) hold_off_req = 1'b1;
            sent = 0;
            while (sent < 25) begin
                r = $urandom_range(0, 99);
                if (r < 70) msg_len = $urandom_range(1, 6);
                else if (r < 95) msg_len = $urandom_range(7, 20);
                else msg_len = $urandom_range(21, 40);
                for (int k = 0; k < msg_len; k++) begin
                    send_byte(8'($urandom_range(0, 255)), k == msg_len - 1, 1'b0, '0);
                end
                sent += msg_len;
            end
            steady = 1'b0;
        end

        drain_encoder();
        if (error_count == 0) begin
            $display("tb_base64_stream_encoder_top: clean");
        end else begin
            $display("tb_base64_stream_encoder_top: errors");
        end
        $finish;
    end

    // receiver: random pop gaps, plus one long hold-off on request
    initial begin : char_sink
        int   gap;
        logic held;
        held = 1'b0;
        pop <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_req && !held) begin
                pop <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                held = 1'b1;
            end else begin
                gap = steady ? 0 : rand_gap();
                if (gap > 0) begin
                    pop <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
        end
    end

    // compare each popped character with the oldest expected one
    always @(posedge i_clk) begin : char_check
        t_out_item want;
        if (i_rst_n && pop && !empty) begin
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected char, expected none actual %h/%b", $time,
                         o_out_item.text_char, o_out_item.last_char);
                error_count++;
            end else begin
                want = expected_chars.pop_front();
                if (o_out_item.text_char !== want.text_char) begin
                    $display("%0t: text_char mismatch, expected %h actual %h", $time,
                             want.text_char, o_out_item.text_char);
                    error_count++;
                end
                if (o_out_item.last_char !== want.last_char) begin
                    $display("%0t: last_char mismatch, expected %b actual %b", $time,
                             want.last_char, o_out_item.last_char);
                    error_count++;
                end
            end
        end
    end

    // overall limit on the run
    initial begin : watchdog
        #5_000_000;
        $display("tb_base64_stream_encoder_top: errors");
        $finish;
    end

endmodule

### filelist.f
rtl/b64e_pkg.sv
rtl/b64e_fifo.sv
rtl/b64e_front.sv
rtl/b64e_back.sv
rtl/base64_stream_encoder_top.sv
verif/tb_base64_stream_encoder_top.sv
